// File: rtl/core/dht_pkg.sv
// shared types and constants for the double hash table
`default_nettype none
package dht_pkg;
    localparam logic [1:0] TAG_EMPTY = 2'd0;
    localparam logic [1:0] TAG_LIVE  = 2'd1;
    localparam logic [1:0] TAG_TOMB  = 2'd2;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_REMOVED   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

    // request handed from the top level to the hash unit
    typedef struct packed {
        logic        start;
        logic [63:0] key;
    } hash_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] pos;
        logic [63:0] step;
    } hash_rsp_t;
endpackage
`default_nettype wire

// File: rtl/core/dht_mulseq.sv
// sequential 64x64 multiplier with full 128-bit product, 16x64 partial product per cycle
`default_nettype none
module dht_mulseq
    import dht_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             done,
    output logic [63:0]      p_lo,
    output logic [63:0]      p_hi
);
    logic [127:0] acc_reg;
    logic [63:0]  a_reg, b_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg, done_reg;
    logic [79:0]  part;
    logic [79:0]  sum;

    // 16-bit slice of b times a, added at the top and shifted down
    assign part = {16'd0, a_reg} * {64'd0, b_reg[15:0]};
    assign sum  = {16'd0, acc_reg[127:64]} + part;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == 3'd3) && !start;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
                acc_reg  <= '0;
                a_reg    <= a;
                b_reg    <= b;
            end else if (busy_reg) begin
                acc_reg  <= {sum, acc_reg[63:16]};
                b_reg    <= b_reg >> 16;
                cnt_reg  <= cnt_reg + 3'd1;
                busy_reg <= (cnt_reg != 3'd3);
            end
        end
    end
    assign done = done_reg;
    assign p_lo = acc_reg[63:0];
    assign p_hi = acc_reg[127:64];
endmodule
`default_nettype wire

// File: rtl/core/dht_hash.sv
// splitmix64 mix, start position and probe step by reciprocal multiplication
`default_nettype none
module dht_hash
    import dht_pkg::*;
#(
    parameter int TABLE_SIZE = 1021
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire hash_req_t req,
    output hash_rsp_t      rsp
);
    typedef enum logic [8:0] {
        H_IDLE = 9'b000000001, H_MIX1 = 9'b000000010, H_MIX2 = 9'b000000100,
        H_QK   = 9'b000001000, H_QZ   = 9'b000010000, H_RK   = 9'b000100000,
        H_RZ   = 9'b001000000, H_FIX  = 9'b010000000, H_DONE = 9'b100000000
    } hstate_t;
    localparam logic [64:0] TWO64 = {1'b1, 64'd0};
    localparam logic [63:0] NMOD  = 64'(TABLE_SIZE);
    localparam logic [63:0] NM1   = 64'(TABLE_SIZE - 1);
    // floor(2^64 / n), so the quotient estimate is low by at most one
    localparam logic [63:0] RCP_K = 64'(TWO64 / 65'(TABLE_SIZE));
    localparam logic [63:0] RCP_Z = 64'(TWO64 / 65'(TABLE_SIZE - 1));

    hstate_t     st_reg;
    logic [63:0] key_reg, z_reg;
    logic [63:0] qk_reg, qz_reg;
    logic [63:0] rk_reg, rz_reg;
    logic        mstart_reg;
    logic        mul_go;
    logic [63:0] ma, mb, mlo, mhi;
    logic        mdone;

    dht_mulseq u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mstart_reg),
        .a(ma), .b(mb), .done(mdone), .p_lo(mlo), .p_hi(mhi)
    );

    // operands for the multiply of the current step
    always_comb begin
        case (st_reg)
            H_MIX1:  begin ma = z_reg;   mb = MIX_C1; end
            H_MIX2:  begin ma = z_reg;   mb = MIX_C2; end
            H_QK:    begin ma = key_reg; mb = RCP_K;  end
            H_QZ:    begin ma = z_reg;   mb = RCP_Z;  end
            H_RK:    begin ma = qk_reg;  mb = NMOD;   end
            H_RZ:    begin ma = qz_reg;  mb = NM1;    end
            default: begin ma = z_reg;   mb = MIX_C1; end
        endcase
    end

    // start the multiplier on entry to every multiply step
    assign mul_go = (st_reg == H_IDLE && req.start)
                    || (mdone && (st_reg inside {H_MIX1, H_MIX2, H_QK, H_QZ, H_RK}));

    always_ff @(posedge aclk) begin
        if (!aresetn) mstart_reg <= 1'b0;
        else mstart_reg <= mul_go;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= H_IDLE;
        end else begin
            case (st_reg)
                H_IDLE: if (req.start) begin
                    key_reg <= req.key;
                    z_reg   <= req.key ^ (req.key >> 30);
                    st_reg  <= H_MIX1;
                end
                H_MIX1: if (mdone) begin
                    z_reg  <= mlo ^ (mlo >> 27);
                    st_reg <= H_MIX2;
                end
                H_MIX2: if (mdone) begin
                    z_reg  <= mlo ^ (mlo >> 31);
                    st_reg <= H_QK;
                end
                H_QK: if (mdone) begin
                    qk_reg <= mhi;
                    st_reg <= H_QZ;
                end
                H_QZ: if (mdone) begin
                    qz_reg <= mhi;
                    st_reg <= H_RK;
                end
                H_RK: if (mdone) begin
                    rk_reg <= key_reg - mlo;
                    st_reg <= H_RZ;
                end
                H_RZ: if (mdone) begin
                    rz_reg <= z_reg - mlo;
                    st_reg <= H_FIX;
                end
                // remainders are below twice the divisor here
                H_FIX: begin
                    rk_reg <= (rk_reg >= NMOD) ? rk_reg - NMOD : rk_reg;
                    rz_reg <= (rz_reg >= NM1) ? rz_reg - NM1 : rz_reg;
                    st_reg <= H_DONE;
                end
                H_DONE: st_reg <= H_IDLE;
                default: st_reg <= H_IDLE;
            endcase
        end
    end
    assign rsp.done = (st_reg == H_DONE);
    assign rsp.pos  = rk_reg;
    assign rsp.step = rz_reg + 64'd1;
endmodule
`default_nettype wire

// File: rtl/core/double_hash_table_core.sv
// top level of the double hashing key/value table
// s_axis: one request word per handshake; tuser = action (0 insert, 1 remove),
// tdata = key (bits 63:0), value_in (bits 127:64).
// m_axis: one result word per request; tdata = status (1:0), value_out (65:2),
// slot (75:66), occupancy (85:76), padded to 88 bits.
// a request passes through the hash unit (six multiplies on one shared
// 64x16-per-cycle multiplier, one correction step and one hand-off step)
// and then probes slots; the tag/key/value memories have one read port,
// so each probe is a read step then a compare step.
// the result word is valid once probing ends; the next request word can be
// taken in the cycle after the result word is taken.
// after reset a clearing pass walks the tag memory one slot per cycle
// with s_axis_tready low.
// results sit in an output register; while m_axis_tready is low the block
// holds the result and takes no new request.
`default_nettype none
module double_hash_table_core
    import dht_pkg::*;
#(
    parameter int TABLE_SIZE = 1021
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,  // key, value_in
    input  wire logic         s_axis_tuser,  // action
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [87:0]       m_axis_tdata   // status, value_out, slot, occupancy
);
    localparam int AW = $clog2(TABLE_SIZE);
    localparam int CW = $clog2(TABLE_SIZE + 1);
    localparam logic [AW:0] NSZ = (AW+1)'(TABLE_SIZE);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001, S_IDLE = 7'b0000010, S_HASH = 7'b0000100,
        S_READ = 7'b0001000, S_CHECK = 7'b0010000, S_OUT = 7'b0100000,
        S_HOLD = 7'b1000000
    } state_t;

    state_t        st_reg;
    logic [1:0]    tag_mem [TABLE_SIZE];
    logic [63:0]   key_mem [TABLE_SIZE];
    logic [63:0]   val_mem [TABLE_SIZE];
    logic [1:0]    tag_rd;
    logic [63:0]   key_rd, val_rd;
    logic [AW-1:0] pos_reg, step_reg;
    logic [CW-1:0] n_reg, live_reg;
    logic          act_reg;
    logic [63:0]   key_reg, vin_reg;
    logic [1:0]    stat_reg;
    logic [63:0]   vout_reg;
    logic [AW-1:0] where_reg;
    logic          we;
    logic [1:0]    wtag;
    logic          hit_free, hit_match, stop_empty;
    logic [AW:0]   psum;
    logic [AW-1:0] pnext;
    hash_req_t     hreq;
    hash_rsp_t     hrsp;

    dht_hash #(.TABLE_SIZE(TABLE_SIZE)) u_hash (
        .aclk(aclk), .aresetn(aresetn), .req(hreq), .rsp(hrsp)
    );
    assign hreq.start = s_axis_tvalid && s_axis_tready;
    assign hreq.key   = s_axis_tdata[63:0];

    assign hit_free   = (tag_rd == TAG_EMPTY) || (tag_rd == TAG_TOMB);
    assign hit_match  = (tag_rd == TAG_LIVE) && (key_rd == key_reg);
    assign stop_empty = (tag_rd == TAG_EMPTY);
    assign psum  = {1'b0, pos_reg} + {1'b0, step_reg};
    assign pnext = (psum >= NSZ) ? AW'(psum - NSZ) : psum[AW-1:0];

    always_comb begin
        we   = 1'b0;
        wtag = TAG_LIVE;
        if (st_reg == S_CHECK) begin
            if (act_reg == ACT_INSERT && hit_free) we = 1'b1;
            if (act_reg == ACT_REMOVE && hit_match) begin
                we   = 1'b1;
                wtag = TAG_TOMB;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (st_reg == S_CLEAR) tag_mem[pos_reg] <= TAG_EMPTY;
        else if (we) tag_mem[pos_reg] <= wtag;
        if (we && act_reg == ACT_INSERT) begin
            key_mem[pos_reg] <= key_reg;
            val_mem[pos_reg] <= vin_reg;
        end
        tag_rd <= tag_mem[pos_reg];
        key_rd <= key_mem[pos_reg];
        val_rd <= val_mem[pos_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= S_CLEAR;
            pos_reg  <= '0;
            live_reg <= '0;
        end else begin
            case (st_reg)
                S_CLEAR: begin
                    if (pos_reg == AW'(TABLE_SIZE - 1)) begin
                        st_reg  <= S_IDLE;
                        pos_reg <= '0;
                    end else begin
                        pos_reg <= pos_reg + AW'(1);
                    end
                end
                S_IDLE: if (s_axis_tvalid) begin
                    act_reg <= s_axis_tuser;
                    key_reg <= s_axis_tdata[63:0];
                    vin_reg <= s_axis_tdata[127:64];
                    st_reg  <= S_HASH;
                end
                S_HASH: if (hrsp.done) begin
                    pos_reg  <= hrsp.pos[AW-1:0];
                    step_reg <= hrsp.step[AW-1:0];
                    n_reg    <= '0;
                    st_reg   <= S_READ;
                end
                S_READ: st_reg <= S_CHECK;
                S_CHECK: begin
                    if (we) begin
                        where_reg <= pos_reg;
                        st_reg    <= S_OUT;
                        if (act_reg == ACT_INSERT) begin
                            stat_reg <= ST_INSERTED;
                            vout_reg <= '0;
                            live_reg <= live_reg + CW'(1);
                        end else begin
                            stat_reg <= ST_REMOVED;
                            vout_reg <= val_rd;
                            if (live_reg != '0) live_reg <= live_reg - CW'(1);
                        end
                    end else begin
                        stat_reg  <= (act_reg == ACT_INSERT) ? ST_FULL : ST_NOT_FOUND;
                        vout_reg  <= '0;
                        where_reg <= '0;
                        if ((act_reg == ACT_REMOVE && stop_empty)
                            || n_reg == CW'(TABLE_SIZE - 1)) begin
                            st_reg <= S_OUT;
                        end else begin
                            pos_reg <= pnext;
                            n_reg   <= n_reg + CW'(1);
                            st_reg  <= S_READ;
                        end
                    end
                end
                S_OUT: st_reg <= S_HOLD;
                S_HOLD: if (m_axis_tready) st_reg <= S_IDLE;
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // occupancy is sampled in S_OUT, the cycle after the count update
    logic [CW-1:0] occ_reg;
    always_ff @(posedge aclk) if (st_reg == S_OUT) occ_reg <= live_reg;

    logic [9:0] slot10, occ10;
    assign slot10 = 10'(where_reg);
    assign occ10  = 10'(occ_reg);

    assign s_axis_tready = (st_reg == S_IDLE);
    assign m_axis_tvalid = (st_reg == S_HOLD);
    assign m_axis_tdata  = {2'b00, occ10, slot10, vout_reg, stat_reg};

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while result pending");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= CW'(TABLE_SIZE))
        else $error("live count above table size");
    a_write_at_check: assert property (@(posedge aclk) disable iff (!aresetn)
        we |-> st_reg == S_CHECK)
        else $error("memory write outside probe check");
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
endmodule
`default_nettype wire
